### rtl/aprt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the antagonist PD ramp tracker.
// No dependencies; imported by aprt_div, antagonist_pd_ramp_tracker and its testbench.
package aprt_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_POSITION_GAIN   = 3'd0,
    REG_VELOCITY_GAIN   = 3'd1,
    REG_LOAD_MASS       = 3'd2,
    REG_MAX_FORCE_LEFT  = 3'd3,
    REG_MAX_FORCE_RIGHT = 3'd4,
    REG_RAMP_SLOPE      = 3'd5,
    REG_RAMP_VELOCITY   = 3'd6,
    REG_HOLD_POSITION   = 3'd7
  } cfg_reg_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int GAIN_W    = 31;
  localparam int FIELD_W   = 32;
  localparam int OUT_W     = 17;

  // Register defaults
  localparam logic [GAIN_W-1:0]         RST_GAIN     = 31'd65536;
  localparam logic signed [FIELD_W-1:0] RST_SLOPE    = 32'sd9290;
  localparam logic signed [FIELD_W-1:0] RST_RAMP_VEL = 32'sd9470;
  localparam logic signed [FIELD_W-1:0] RST_HOLD_POS = 32'sd1258;

  // Which actuator a force request drives
  typedef struct packed {
    logic neg;  // force below zero: left side pulls
    logic nz;   // force not zero
  } side_t;

endpackage

### rtl/aprt_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: drive = min((mag << FRAC_BITS) / fmax, 1.0).
// A clamp compare stage, then one quotient bit per stage; uses aprt_pkg for the side struct.
module aprt_div import aprt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MAG_W     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAG_W-1:0]     in_mag,
  input  logic [GAIN_W-1:0]    in_fmax,
  input  side_t                in_ctl,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   out_drive,
  output side_t                out_ctl
);

  localparam int NST   = FRAC_BITS + 1;
  localparam int FW    = GAIN_W;
  localparam int CMP_W = (MAG_W > FW) ? MAG_W : FW;
  localparam logic [FRAC_BITS:0] DRV_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [NST-1:0]       v_r;
  logic [NST-1:0]       en;
  logic [FW-1:0]        rem_r  [0:FRAC_BITS-1];
  logic [FRAC_BITS-1:0] quo_r  [0:FRAC_BITS-1];
  logic [FW-1:0]        fmax_r [0:FRAC_BITS-1];
  logic                 clamp_r [0:FRAC_BITS-1];
  side_t                ctl_r  [0:FRAC_BITS-1];
  logic [FRAC_BITS:0]   drive_r;
  side_t                out_ctl_r;

  logic                 clamp_nxt;
  logic [FW-1:0]        rem0_nxt;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Quotient of 1.0 or more clamps; otherwise mag < fmax fits the remainder
  always_comb begin
    clamp_nxt = CMP_W'(in_mag) >= CMP_W'(in_fmax);
    rem0_nxt  = clamp_nxt ? '0 : FW'(in_mag);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]   <= rem0_nxt;
      quo_r[0]   <= '0;
      fmax_r[0]  <= in_fmax;
      clamp_r[0] <= clamp_nxt;
      ctl_r[0]   <= in_ctl;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [FW:0]          shl;
    logic                 ge;
    logic [FRAC_BITS-1:0] quo_nxt;

    always_comb begin
      shl     = {rem_r[k-1], 1'b0};
      ge      = shl >= {1'b0, fmax_r[k-1]};
      quo_nxt = {quo_r[k-1][FRAC_BITS-2:0], ge};
    end

    if (k < FRAC_BITS) begin : g_mid
      logic [FW-1:0] rem_nxt;

      always_comb begin
        rem_nxt = ge ? FW'(shl - {1'b0, fmax_r[k-1]}) : FW'(shl);
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k]   <= rem_nxt;
          quo_r[k]   <= quo_nxt;
          fmax_r[k]  <= fmax_r[k-1];
          clamp_r[k] <= clamp_r[k-1];
          ctl_r[k]   <= ctl_r[k-1];
        end
      end
    end else begin : g_last
      logic [FRAC_BITS:0] drive_nxt;

      always_comb begin
        if (!ctl_r[k-1].nz) begin
          drive_nxt = '0;
        end else if (clamp_r[k-1]) begin
          drive_nxt = DRV_ONE;
        end else begin
          drive_nxt = {1'b0, quo_nxt};
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          drive_r   <= drive_nxt;
          out_ctl_r <= ctl_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_drive = drive_r;
  assign out_ctl   = out_ctl_r;

`ifndef NO_ASSERTIONS
  a_drive_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive <= DRV_ONE)
    else $error("drive above full scale");

  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ctl.nz |-> out_drive == '0)
    else $error("zero force gave a nonzero drive");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0] && v_r[NST-1] && out_stall)
    else $error("divider refused a request with room in the pipe");
`endif

endmodule

### rtl/antagonist_pd_ramp_tracker.sv
`timescale 1ns / 1ps
// Antagonist PD ramp tracker: ramp reference, PD force and left/right drive split.
// Depends on aprt_pkg and aprt_div.
//
// Usage:
//   Input requests carry time, measured position and velocity (Q format with
//   FRAC_BITS fraction bits) on in_valid / in_stall. Each request produces one
//   result with left and right drive on out_valid / out_stall; 1.0 is
//   2^FRAC_BITS, masked to 17 bits.
//   The pipeline has ten arithmetic stages (ramp multiply, errors, PD
//   multiplies, mass multiply, magnitude) and FRAC_BITS + 1 divider stages: a
//   clamp compare, then one quotient bit per stage.
//   Throughput is one request per cycle while in_stall is low.
//   When the receiver stalls, the result holds on the outputs; empty stages
//   behind it keep filling, and in_stall rises only once every stage is full.
//   The cfg port writes one register per cycle with cfg_write_en; write only
//   while no request is in flight.
//   Synchronous reset empties the pipeline and loads the register defaults.
module antagonist_pd_ramp_tracker import aprt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FIELD_W-1:0]        in_time_now,
  input  logic signed [FIELD_W-1:0] in_position_now,
  input  logic signed [FIELD_W-1:0] in_velocity_now,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_W-1:0]          out_left_drive,
  output logic [OUT_W-1:0]          out_right_drive
);

  localparam int SW   = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam int WIDE = 72;
  localparam int NS   = 10;
  localparam int PW   = GAIN_W + 1 + SW;
  localparam int DRV_W = FRAC_BITS + 1;
  localparam int EXT_W = (DRV_W > OUT_W) ? DRV_W : OUT_W;

  localparam longint unsigned ONE_Q  = 64'd1 << FRAC_BITS;
  localparam longint unsigned RISE_Q = ((64'd12 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [FIELD_W-1:0] T_ONE = FIELD_W'(ONE_Q);
  localparam logic [FIELD_W-1:0] T_END = FIELD_W'(ONE_Q + RISE_Q);

  localparam logic signed [WIDE-1:0] SAT_HI = {{(WIDE-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WIDE-1:0] SAT_LO = {{(WIDE-SW+1){1'b1}}, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat_w(input logic signed [WIDE-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[SW-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[SW-1:0];
    end
    return x[SW-1:0];
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0]         kp_r, kv_r, mass_r, fmax_left_r, fmax_right_r;
  logic signed [FIELD_W-1:0] slope_r, ramp_vel_r, hold_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r         <= RST_GAIN;
      kv_r         <= RST_GAIN;
      mass_r       <= RST_GAIN;
      fmax_left_r  <= RST_GAIN;
      fmax_right_r <= RST_GAIN;
      slope_r      <= RST_SLOPE;
      ramp_vel_r   <= RST_RAMP_VEL;
      hold_pos_r   <= RST_HOLD_POS;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POSITION_GAIN:   kp_r         <= cfg_data[GAIN_W-1:0];
        REG_VELOCITY_GAIN:   kv_r         <= cfg_data[GAIN_W-1:0];
        REG_LOAD_MASS:       mass_r       <= cfg_data[GAIN_W-1:0];
        REG_MAX_FORCE_LEFT:  fmax_left_r  <= cfg_data[GAIN_W-1:0];
        REG_MAX_FORCE_RIGHT: fmax_right_r <= cfg_data[GAIN_W-1:0];
        REG_RAMP_SLOPE:      slope_r      <= $signed(cfg_data);
        REG_RAMP_VELOCITY:   ramp_vel_r   <= $signed(cfg_data);
        REG_HOLD_POSITION:   hold_pos_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and load enables
  logic [NS:1] v_r;
  logic [NS:1] en;
  logic        div_ready;

  always_comb begin
    en[NS] = !v_r[NS] || div_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: classify time, elapsed ramp time
  logic                      s1_ramp_r, s1_hold_r;
  logic [FIELD_W-1:0]        s1_dt_r;
  logic signed [FIELD_W-1:0] s1_pos_r, s1_vel_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ramp_r <= (in_time_now > T_ONE) && (in_time_now < T_END);
      s1_hold_r <= in_time_now >= T_END;
      s1_dt_r   <= in_time_now - T_ONE;
      s1_pos_r  <= in_position_now;
      s1_vel_r  <= in_velocity_now;
    end
  end

  // Stage 2: slope times elapsed time, pick velocity reference
  logic signed [FIELD_W:0]     s1_dt_s;
  logic signed [2*FIELD_W:0]   s2_prod_nxt;
  logic signed [2*FIELD_W:0]   s2_prod_r;
  logic                        s2_ramp_r, s2_hold_r;
  logic signed [FIELD_W-1:0]   s2_vref_r, s2_pos_r, s2_vel_r;

  always_comb begin
    s1_dt_s     = $signed({1'b0, s1_dt_r});
    s2_prod_nxt = slope_r * s1_dt_s;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_prod_r <= s2_prod_nxt;
      s2_ramp_r <= s1_ramp_r;
      s2_hold_r <= s1_hold_r;
      s2_vref_r <= s1_ramp_r ? ramp_vel_r : '0;
      s2_pos_r  <= s1_pos_r;
      s2_vel_r  <= s1_vel_r;
    end
  end

  // Stage 3: position reference
  logic signed [FIELD_W-1:0] s3_pref_nxt;
  logic signed [FIELD_W-1:0] s3_pref_r, s3_vref_r, s3_pos_r, s3_vel_r;

  always_comb begin
    priority if (s2_ramp_r) begin
      s3_pref_nxt = FIELD_W'(sat_w(WIDE'(s2_prod_r >>> FRAC_BITS)));
    end else if (s2_hold_r) begin
      s3_pref_nxt = hold_pos_r;
    end else begin
      s3_pref_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_pref_r <= s3_pref_nxt;
      s3_vref_r <= s2_vref_r;
      s3_pos_r  <= s2_pos_r;
      s3_vel_r  <= s2_vel_r;
    end
  end

  // Stage 4: tracking errors
  logic signed [SW-1:0] s4_ep_r, s4_ev_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_ep_r <= sat_w(WIDE'(s3_pref_r) - WIDE'(s3_pos_r));
      s4_ev_r <= sat_w(WIDE'(s3_vref_r) - WIDE'(s3_vel_r));
    end
  end

  // Stage 5: gain products
  logic signed [GAIN_W:0] kp_s, kv_s, mass_s;
  logic signed [PW-1:0]   s5_pp_nxt, s5_pv_nxt;
  logic signed [PW-1:0]   s5_pp_r, s5_pv_r;

  always_comb begin
    kp_s      = $signed({1'b0, kp_r});
    kv_s      = $signed({1'b0, kv_r});
    mass_s    = $signed({1'b0, mass_r});
    s5_pp_nxt = kp_s * s4_ep_r;
    s5_pv_nxt = kv_s * s4_ev_r;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pp_r <= s5_pp_nxt;
      s5_pv_r <= s5_pv_nxt;
    end
  end

  // Stage 6: scale back, floor rounding
  logic signed [SW-1:0] s6_qp_r, s6_qv_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_qp_r <= sat_w(WIDE'(s5_pp_r >>> FRAC_BITS));
      s6_qv_r <= sat_w(WIDE'(s5_pv_r >>> FRAC_BITS));
    end
  end

  // Stage 7: acceleration command
  logic signed [SW-1:0] s7_acc_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_acc_r <= sat_w(WIDE'(s6_qp_r) + WIDE'(s6_qv_r));
    end
  end

  // Stage 8: times load mass
  logic signed [PW-1:0] s8_fp_nxt;
  logic signed [PW-1:0] s8_fp_r;

  always_comb begin
    s8_fp_nxt = s7_acc_r * mass_s;
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_fp_r <= s8_fp_nxt;
    end
  end

  // Stage 9: force
  logic signed [SW-1:0] s9_force_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_force_r <= sat_w(WIDE'(s8_fp_r >>> FRAC_BITS));
    end
  end

  // Stage 10: magnitude and side select
  logic [SW-1:0]     s10_mag_r;
  logic [GAIN_W-1:0] s10_fmax_r;
  side_t             s10_ctl_r;
  logic              s9_neg;

  assign s9_neg = s9_force_r < 0;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_mag_r     <= s9_neg ? SW'(-s9_force_r) : SW'(s9_force_r);
      s10_fmax_r    <= s9_neg ? fmax_left_r : fmax_right_r;
      s10_ctl_r.neg <= s9_neg;
      s10_ctl_r.nz  <= s9_force_r != 0;
    end
  end

  // Drive quotient
  logic [FRAC_BITS:0] div_drive;
  side_t              div_ctl;
  logic [EXT_W-1:0]   drive_ext;

  aprt_div #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[NS]),
    .in_ready  (div_ready),
    .in_mag    (s10_mag_r),
    .in_fmax   (s10_fmax_r),
    .in_ctl    (s10_ctl_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_drive (div_drive),
    .out_ctl   (div_ctl)
  );

  assign drive_ext       = EXT_W'(div_drive);
  assign out_left_drive  = div_ctl.neg ? drive_ext[OUT_W-1:0] : '0;
  assign out_right_drive = div_ctl.neg ? '0 : drive_ext[OUT_W-1:0];

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_drive == '0) || (out_right_drive == '0))
    else $error("both actuators driven at once");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[1] && v_r[NS] && !div_ready)
    else $error("input stalled with room in the pipe");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] && !div_ready |=> v_r[NS] && $stable(s10_mag_r) && $stable(s10_ctl_r))
    else $error("request dropped at divider entry");
`endif

endmodule

### tb/antagonist_pd_ramp_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for antagonist_pd_ramp_tracker: a scoreboard class predicts the
// left/right drives of every accepted request and matches them against the result port.
// Depends on aprt_pkg and the tracker RTL.
module antagonist_pd_ramp_tracker_tb import aprt_pkg::*; ();

  localparam int     FRAC         = 16;
  localparam int     ONE_Q        = 1 << FRAC;
  localparam int     RISE_Q       = ((12 << FRAC) + 50) / 100;
  localparam int     PIPE_LATENCY = FRAC + 11;
  localparam int     HOLD_CYCLES  = 3 * PIPE_LATENCY + 20;
  localparam int     CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] right;
  } drive_pair_t;

  class drive_scoreboard;
    longint kp, kv, mass, fmax_l, fmax_r, slope, ramp_vel, hold_pos;
    drive_pair_t expected_drives[$];
    int failures;

    function new();
      kp = 65536;
      kv = 65536;
      mass = 65536;
      fmax_l = 65536;
      fmax_r = 65536;
      slope = 9290;
      ramp_vel = 9470;
      hold_pos = 1258;
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_POSITION_GAIN:   kp = longint'(val[GAIN_W-1:0]);
        REG_VELOCITY_GAIN:   kv = longint'(val[GAIN_W-1:0]);
        REG_LOAD_MASS:       mass = longint'(val[GAIN_W-1:0]);
        REG_MAX_FORCE_LEFT:  fmax_l = longint'(val[GAIN_W-1:0]);
        REG_MAX_FORCE_RIGHT: fmax_r = longint'(val[GAIN_W-1:0]);
        REG_RAMP_SLOPE:      slope = longint'($signed(val));
        REG_RAMP_VELOCITY:   ramp_vel = longint'($signed(val));
        REG_HOLD_POSITION:   hold_pos = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // exact product, floor shift, saturate
    function longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> FRAC);
    endfunction

    function logic [OUT_W-1:0] drive_share(longint mag, longint fmax);
      longint q;
      if (mag <= 0) return '0;
      if (fmax <= 0) return OUT_W'(ONE_Q);
      q = (mag << FRAC) / fmax;
      if (q > longint'(ONE_Q)) q = longint'(ONE_Q);
      return q[OUT_W-1:0];
    endfunction

    function drive_pair_t predict_drives(logic [31:0] t_raw, logic [31:0] pos_raw,
                                         logic [31:0] vel_raw);
      longint t, pos, vel, pref, vref, pos_err, vel_err, accel, force_q;
      drive_pair_t d;
      t = longint'(t_raw);
      pos = longint'($signed(pos_raw));
      vel = longint'($signed(vel_raw));
      pref = 0;
      vref = 0;
      if (t > longint'(ONE_Q)) begin
        if (t < longint'(ONE_Q + RISE_Q)) begin
          pref = fx_mul(slope, t - longint'(ONE_Q));
          vref = ramp_vel;
        end else begin
          pref = hold_pos;
        end
      end
      pos_err = clamp_word(pref - pos);
      vel_err = clamp_word(vref - vel);
      accel = clamp_word(fx_mul(kp, pos_err) + fx_mul(kv, vel_err));
      force_q = fx_mul(accel, mass);
      d.left = '0;
      d.right = '0;
      // negative force pulls left, positive pulls right
      if (force_q < 0) d.left = drive_share(-force_q, fmax_l);
      else if (force_q > 0) d.right = drive_share(force_q, fmax_r);
      return d;
    endfunction

    function void note_request(logic [31:0] t, logic [31:0] pos, logic [31:0] vel);
      expected_drives.push_back(predict_drives(t, pos, vel));
    endfunction

    function void check_drive(logic [OUT_W-1:0] left, logic [OUT_W-1:0] right);
      drive_pair_t want;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d", $time, left, right);
        failures++;
        return;
      end
      want = expected_drives.pop_front();
      if (left !== want.left) begin
        $display("%0t: left drive expected %0d, got %0d", $time, want.left, left);
        failures++;
      end
      if (right !== want.right) begin
        $display("%0t: right drive expected %0d, got %0d", $time, want.right, right);
        failures++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FIELD_W-1:0]        in_time_now = '0;
  logic signed [FIELD_W-1:0] in_position_now = '0;
  logic signed [FIELD_W-1:0] in_velocity_now = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [OUT_W-1:0]          out_left_drive;
  logic [OUT_W-1:0]          out_right_drive;

  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int   hold_off_count = 0;
  int   hold_offs_served = 0;
  int   cycle_count = 0;

  drive_scoreboard sb;

  antagonist_pd_ramp_tracker #(.DATA_WIDTH(32), .FRAC_BITS(FRAC)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_time_now     (in_time_now),
    .in_position_now (in_position_now),
    .in_velocity_now (in_velocity_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_time_now, in_position_now, in_velocity_now);
    if (rst_n && out_valid && !out_stall)
      sb.check_drive(out_left_drive, out_right_drive);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("antagonist_pd_ramp_tracker test failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_count != hold_offs_served) begin
        hold_offs_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(99) < 9);
      end
    end
  end

  task automatic send_request(logic [31:0] t, logic [31:0] pos, logic [31:0] vel);
    in_valid <= 1'b1;
    in_time_now <= t;
    in_position_now <= pos;
    in_velocity_now <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!tx_quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(logic [31:0] kp, logic [31:0] kv, logic [31:0] mass,
                               logic [31:0] fl, logic [31:0] fr, logic [31:0] slope,
                               logic [31:0] rvel, logic [31:0] hold);
    write_reg(REG_POSITION_GAIN, kp);
    write_reg(REG_VELOCITY_GAIN, kv);
    write_reg(REG_LOAD_MASS, mass);
    write_reg(REG_MAX_FORCE_LEFT, fl);
    write_reg(REG_MAX_FORCE_RIGHT, fr);
    write_reg(REG_RAMP_SLOPE, slope);
    write_reg(REG_RAMP_VELOCITY, rvel);
    write_reg(REG_HOLD_POSITION, hold);
    cfg_write_en <= 1'b0;
  endtask

  // Wait out every expected drive, then let the pipeline settle before any write
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  // Bias time toward the ramp window and its boundaries
  function automatic logic [31:0] pick_time();
    case ($urandom_range(5))
      0: return $urandom_range(ONE_Q);
      1, 2: return ONE_Q + $urandom_range(RISE_Q);
      3: return ONE_Q + RISE_Q + $urandom_range(200000);
      4: begin
        case ($urandom_range(3))
          0: return ONE_Q;
          1: return ONE_Q + 1;
          2: return ONE_Q + RISE_Q - 1;
          default: return ONE_Q + RISE_Q;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_signal();
    case ($urandom_range(5))
      0: return $urandom();
      1: return pick_extreme();
      default: return $urandom_range(262144) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1024);
      default: return $urandom_range(1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] pick_force_limit();
    case ($urandom_range(11))
      0: return 32'h0;
      1: return $urandom();
      default: return $urandom_range(1 << 22, 1 << 10);
    endcase
  endfunction

  function automatic logic [31:0] pick_ref();
    case ($urandom_range(7))
      0: return $urandom();
      default: return $urandom_range(1 << 18) - (1 << 17);
    endcase
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(pick_time(), pick_signal(), pick_signal());
    drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: ramp edges, zero force, clamped and tiny drives
    send_request(32'h0, 32'h0, 32'h0);
    send_request(ONE_Q, 32'h0, 32'h0);
    send_request(ONE_Q - 1, 32'd5000, 32'h0);
    send_request(ONE_Q + 1, 32'h0, 32'h0);
    send_request(ONE_Q + RISE_Q / 2, 32'h0, 32'h0);
    send_request(ONE_Q + RISE_Q - 1, 32'h0, 32'h0);
    send_request(ONE_Q + RISE_Q, 32'h0, 32'h0);
    send_request(ONE_Q + RISE_Q + 1, 32'd1258, 32'h0);
    send_request(32'hFFFF_FFFF, 32'd1258, 32'h0);
    send_request(32'h0, 32'h7FFF_FFFF, 32'h0);
    send_request(32'h0, 32'h8000_0000, 32'h0);
    send_request(32'h0, 32'h0, 32'h7FFF_FFFF);
    send_request(32'h0, 32'h0, 32'h8000_0000);
    send_request(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h0, 32'h8000_0000, 32'h8000_0000);
    send_request(32'h0, 32'd100, -32'sd100);
    send_request(32'h0, 32'd1, 32'h0);
    send_request(32'h0, -32'sd1, 32'h0);
    send_request(ONE_Q + RISE_Q / 2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // Largest gains, smallest divisors, reference extremes; bit 31 of a gain is dropped
    load_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(40);

    // Zero divisors on both sides, one of them through the dropped top bit
    load_settings(32'h0, 32'h8001_0000, 32'h0001_0000, 32'h8000_0000, 32'h0,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    run_random(40);

    // Zero mass: force is always zero
    load_settings(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
                  32'd9290, 32'd9470, 32'd1258);
    run_random(20);

    for (int ph = 0; ph < 5; ph++) begin
      load_settings(pick_gain(), pick_gain(), pick_gain(), pick_force_limit(),
                    pick_force_limit(), pick_ref(), pick_ref(), pick_ref());
      tx_quiet <= (ph == 2) || (ph == 3);
      rx_quiet <= (ph == 2);
      // fill the pipeline against a long receiver hold-off
      if (ph == 3) hold_off_count <= hold_off_count + 1;
      run_random(100);
      tx_quiet <= 1'b0;
      rx_quiet <= 1'b0;
    end

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.failures == 0 && sb.expected_drives.size() == 0)
      $display("antagonist_pd_ramp_tracker test passed");
    else
      $display("antagonist_pd_ramp_tracker test failed");
    $finish;
  end

endmodule
